// ===== design/cce_pkg.sv =====
// cce_pkg: shared constants, codes and request structs of the clause evaluator
// no dependencies; imported by cce_clause_mem, cce_scan_ctrl and cnf_clause_evaluator
package cce_pkg;

   // formula limits
   localparam int NumVars     = 64;
   localparam int MaxClauses  = 256;
   localparam int MaxLiterals = 4;

   // field and index widths
   localparam int LitW    = 8;
   localparam int LenW    = 3;
   localparam int RowW    = $clog2(MaxClauses);
   localparam int SlotW   = $clog2(MaxLiterals);
   localparam int CountW  = $clog2(MaxClauses + 1);
   localparam int AssignW = 64;
   localparam int VarIdxW = $clog2(NumVars);
   localparam int ActionW = 2;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 9;

   // request action codes
   typedef enum logic [ActionW-1:0] {
      ACT_STORE  = 2'd0,
      ACT_LENGTH = 2'd1,
      ACT_EVAL   = 2'd2
   } action_type;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_CLAUSE_COUNT = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_EARLY_STOP   = 1'b1;

   // write request into the clause memory
   typedef struct packed {
      logic             lit_we;
      logic             len_we;
      logic [RowW-1:0]  row;
      logic [SlotW-1:0] slot;
      logic [LitW-1:0]  literal;
      logic [LenW-1:0]  length;
   } mem_wr_type;

   // row read request into the clause memory
   typedef struct packed {
      logic            en;
      logic [RowW-1:0] row;
   } mem_rd_type;

endpackage

// ===== design/cce_clause_mem.sv =====
// cce_clause_mem: clause table, one row of literals plus its length per clause
// depends on cce_pkg; read data registered, one row per cycle
module cce_clause_mem
   import cce_pkg::*;
(
   input  logic                                 clock,
   input  mem_wr_type                           wr,
   input  mem_rd_type                           rd,
   output logic [MaxLiterals-1:0][LitW-1:0]     rd_lits,
   output logic [LenW-1:0]                      rd_len
);

   logic [MaxLiterals-1:0][LitW-1:0] lit_mem [MaxClauses];
   logic [LenW-1:0]                  len_mem [MaxClauses];
   logic [MaxLiterals-1:0][LitW-1:0] rd_lits_ff;
   logic [LenW-1:0]                  rd_len_ff;

   // slot-wide literal writes and length writes
   always_ff @(posedge clock) begin
      if (wr.lit_we) begin
         lit_mem[wr.row][wr.slot] <= wr.literal;
      end
      if (wr.len_we) begin
         len_mem[wr.row] <= wr.length;
      end
   end

   // synchronous row read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_lits_ff <= lit_mem[rd.row];
         rd_len_ff  <= len_mem[rd.row];
      end
   end

   assign rd_lits = rd_lits_ff;
   assign rd_len  = rd_len_ff;

endmodule

// ===== design/cce_scan_ctrl.sv =====
// cce_scan_ctrl: request sequencer, clause scan over the memory and response registers
// depends on cce_pkg; drives the read port of cce_clause_mem
module cce_scan_ctrl
   import cce_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ActionW-1:0]                action,
   input  logic [AssignW-1:0]                assignment,
   input  logic [CountW-1:0]                 clause_count,
   input  logic                              early_stop,
   output mem_rd_type                        rd,
   input  logic [MaxLiterals-1:0][LitW-1:0]  rd_lits,
   input  logic [LenW-1:0]                   rd_len,
   output logic                              rsp_valid,
   output logic                              rsp_is_evaluation,
   output logic                              rsp_all_satisfied,
   output logic [CountW-1:0]                 rsp_satisfied_count
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [CountW-1:0]    issue_ff, issue_in;
   logic [CountW-1:0]    n_ff, n_in;
   logic                 early_ff, early_in;
   logic [AssignW-1:0]   assign_ff, assign_in;
   logic [CountW-1:0]    sat_ff, sat_in;
   logic                 all_ff, all_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic                 eval_last_ff, eval_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_eval_ff, rsp_eval_in;
   logic                 rsp_all_ff, rsp_all_in;
   logic [CountW-1:0]    rsp_count_ff, rsp_count_in;

   logic                 accept;
   logic [CountW-1:0]    n_clamped;
   logic [LenW-1:0]      len_clamped;
   logic                 clause_holds;
   logic                 finish;
   logic [LitW-1:0]      mag;
   logic [LitW-1:0]      mag_m1;
   logic                 neg;

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;

   // clause count limited to the table depth
   assign n_clamped = (clause_count > CountW'(MaxClauses)) ? CountW'(MaxClauses)
                                                           : clause_count;

   // read one row per cycle while rows remain
   always_comb begin
      rd.en  = (state_ff == ST_SCAN) && (issue_ff < n_ff);
      rd.row = issue_ff[RowW-1:0];
   end

   // clause test on the registered row: any used literal that holds
   assign len_clamped = (rd_len > LenW'(MaxLiterals)) ? LenW'(MaxLiterals) : rd_len;

   always_comb begin
      clause_holds = 1'b0;
      mag          = '0;
      mag_m1       = '0;
      neg          = 1'b0;
      for (int s = 0; s < MaxLiterals; s++) begin
         neg    = rd_lits[s][LitW-1];
         mag    = neg ? LitW'(~rd_lits[s] + LitW'(1)) : rd_lits[s];
         mag_m1 = mag - LitW'(1);
         if ((LenW'(s) < len_clamped) && (mag != '0) && (mag <= LitW'(NumVars))) begin
            if (assign_ff[mag_m1[VarIdxW-1:0]] ^ neg) begin
               clause_holds = 1'b1;
            end
         end
      end
   end

   assign finish = eval_vld_ff && ((!clause_holds && early_ff) || eval_last_ff);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      n_in         = n_ff;
      early_in     = early_ff;
      assign_in    = assign_ff;
      sat_in       = sat_ff;
      all_in       = all_ff;
      eval_vld_in  = 1'b0;
      eval_last_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_eval_in  = rsp_eval_ff;
      rsp_all_in   = rsp_all_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action == ACT_EVAL) begin
                  if (n_clamped == '0) begin
                     // no clauses: answer at once
                     rsp_valid_in = 1'b1;
                     rsp_eval_in  = 1'b1;
                     rsp_all_in   = 1'b1;
                     rsp_count_in = '0;
                  end else begin
                     state_in  = ST_SCAN;
                     issue_in  = '0;
                     n_in      = n_clamped;
                     early_in  = early_stop;
                     assign_in = assignment;
                     sat_in    = '0;
                     all_in    = 1'b1;
                  end
               end else begin
                  // writes and the unused code answer with zeros
                  rsp_valid_in = 1'b1;
                  rsp_eval_in  = 1'b0;
                  rsp_all_in   = 1'b0;
                  rsp_count_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (rd.en) begin
               issue_in     = issue_ff + CountW'(1);
               eval_vld_in  = 1'b1;
               eval_last_in = (issue_ff == n_ff - CountW'(1));
            end
            if (eval_vld_ff) begin
               sat_in = sat_ff + CountW'(clause_holds);
               all_in = all_ff && clause_holds;
            end
            if (finish) begin
               state_in     = ST_IDLE;
               eval_vld_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_eval_in  = 1'b1;
               rsp_all_in   = all_ff && clause_holds;
               rsp_count_in = sat_ff + CountW'(clause_holds);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan and response payload
   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      n_ff         <= n_in;
      early_ff     <= early_in;
      assign_ff    <= assign_in;
      sat_ff       <= sat_in;
      all_ff       <= all_in;
      eval_last_ff <= eval_last_in;
      rsp_eval_ff  <= rsp_eval_in;
      rsp_all_ff   <= rsp_all_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_evaluation   = rsp_eval_ff;
   assign rsp_all_satisfied   = rsp_all_ff;
   assign rsp_satisfied_count = rsp_count_ff;

   // a response follows a taken request or the end of a scan
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept || (state_ff == ST_SCAN)))
      else $error("response without a request");

   // the block is free again when a response is shown
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("response while scanning");

   // row data is only evaluated during a scan
   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (state_ff == ST_SCAN))
      else $error("row evaluated outside a scan");

   // the read pointer never passes the clause count
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff <= n_ff))
      else $error("read pointer beyond clause count");

   // non-evaluation responses carry zeros
   a_write_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_eval_ff) |-> (!rsp_all_ff && (rsp_count_ff == '0)))
      else $error("write response not zero");

endmodule

// ===== design/cnf_clause_evaluator.sv =====
// cnf_clause_evaluator: top level, configuration registers, clause memory and scan control
// depends on cce_pkg, cce_clause_mem and cce_scan_ctrl
//
// A request is taken at a rising edge with start high and busy low. Store and length
// requests write the clause memory at that edge and answer in the next cycle with all
// fields zero; busy stays low, so a new request may follow in every cycle. An evaluate
// request scans clause rows from the clause memory, one row per cycle through its single
// read port, over the clause count limited to 256; its response is registered after the
// last row is evaluated, or earlier when early stop ends the scan, and without a scan for
// zero clauses. busy is high during the scan and low again in the response cycle.
// Every response is shown for exactly one cycle under rsp_valid and cannot be held off,
// so the receiver must take it in that cycle. Memory contents are undefined until written.
module cnf_clause_evaluator
   import cce_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ActionW-1:0]         req_action,
   input  logic [RowW-1:0]            req_clause_index,
   input  logic [SlotW-1:0]           req_slot_index,
   input  logic signed [LitW-1:0]     req_literal,
   input  logic [LenW-1:0]            req_clause_length,
   input  logic [AssignW-1:0]         req_assignment,
   output logic                       rsp_valid,
   output logic                       rsp_is_evaluation,
   output logic                       rsp_all_satisfied,
   output logic [CountW-1:0]          rsp_satisfied_count,
   input  logic                       csr_we,
   input  logic [CsrIdxW-1:0]         csr_index,
   input  logic [CsrDataW-1:0]        csr_wdata
);

   logic [CountW-1:0]                clause_count_ff;
   logic                             early_stop_ff;
   logic                             accept;
   mem_wr_type                       wr;
   mem_rd_type                       rd;
   logic [MaxLiterals-1:0][LitW-1:0] rd_lits;
   logic [LenW-1:0]                  rd_len;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clause_count_ff <= '0;
         early_stop_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLAUSE_COUNT: clause_count_ff <= csr_wdata[CountW-1:0];
            CSR_EARLY_STOP:   early_stop_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // table writes at the edge the request is taken
   assign accept = start && !busy;

   always_comb begin
      wr.lit_we  = accept && (req_action == ACT_STORE);
      wr.len_we  = accept && (req_action == ACT_LENGTH);
      wr.row     = req_clause_index;
      wr.slot    = req_slot_index;
      wr.literal = req_literal;
      wr.length  = req_clause_length;
   end

   cce_clause_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_lits (rd_lits),
      .rd_len  (rd_len)
   );

   cce_scan_ctrl u_scan (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .action              (req_action),
      .assignment          (req_assignment),
      .clause_count        (clause_count_ff),
      .early_stop          (early_stop_ff),
      .rd                  (rd),
      .rd_lits             (rd_lits),
      .rd_len              (rd_len),
      .rsp_valid           (rsp_valid),
      .rsp_is_evaluation   (rsp_is_evaluation),
      .rsp_all_satisfied   (rsp_all_satisfied),
      .rsp_satisfied_count (rsp_satisfied_count)
   );

endmodule

// ===== tb/tb_cnf_clause_evaluator.sv =====
`timescale 1ns / 1ps
// tb_cnf_clause_evaluator: self-checking testbench of the CNF clause evaluator
// drives store, length and evaluate requests with random sender gaps and checks each
// response against a behavioural predictor; depends on cce_pkg and cnf_clause_evaluator
module tb_cnf_clause_evaluator;
   import cce_pkg::*;

   localparam int     ClockPeriod  = 8;
   localparam int     ResetCycles  = 5;
   localparam longint TimeoutNs    = 10_000_000;
   localparam int     AnswerWait   = 600;
   localparam int     SettleCycles = 300;
   localparam int     MaxPrinted   = 30;

   // action code with no meaning, answered with zeros
   localparam logic [ActionW-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [ActionW-1:0]      action;
      logic [RowW-1:0]         clause;
      logic [SlotW-1:0]        slot;
      logic signed [LitW-1:0]  literal;
      logic [LenW-1:0]         length;
      logic [AssignW-1:0]      assignment;
   } clause_req_type;

   typedef struct {
      logic              is_eval;
      logic              all_sat;
      logic [CountW-1:0] count;
   } answer_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [ActionW-1:0]     req_action = '0;
   logic [RowW-1:0]        req_clause_index = '0;
   logic [SlotW-1:0]       req_slot_index = '0;
   logic signed [LitW-1:0] req_literal = '0;
   logic [LenW-1:0]        req_clause_length = '0;
   logic [AssignW-1:0]     req_assignment = '0;
   logic                   rsp_valid;
   logic                   rsp_is_evaluation;
   logic                   rsp_all_satisfied;
   logic [CountW-1:0]      rsp_satisfied_count;
   logic                   csr_we = 1'b0;
   logic [CsrIdxW-1:0]     csr_index = '0;
   logic [CsrDataW-1:0]    csr_wdata = '0;

   // request queue, the request on the ports and the answers still to come
   clause_req_type pending_requests[$];
   clause_req_type on_port;
   answer_type     pending_answers[$];

   // predictor copy of the clause memory and the registers
   logic signed [LitW-1:0] lit_tab [MaxClauses][MaxLiterals];
   logic [LenW-1:0]        len_tab [MaxClauses];
   logic [CsrDataW-1:0]    cfg_clause_count = '0;
   logic                   cfg_early_stop = 1'b0;

   // what the generator has written so far, ahead of the driver
   bit                     len_known [MaxClauses];
   bit                     lit_known [MaxClauses][MaxLiterals];
   logic [LenW-1:0]        plan_len [MaxClauses];
   logic signed [LitW-1:0] plan_lit [MaxClauses][MaxLiterals];
   int                     plan_count = 0;
   int                     queued_items = 0;

   int sender_idle_pct = 31;
   int errors = 0;
   int n_requests = 0;
   int n_evals = 0;
   int n_full = 0;
   int n_cut = 0;
   int n_settings = 0;

   cnf_clause_evaluator i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_clause_index    (req_clause_index),
      .req_slot_index      (req_slot_index),
      .req_literal         (req_literal),
      .req_clause_length   (req_clause_length),
      .req_assignment      (req_assignment),
      .rsp_valid           (rsp_valid),
      .rsp_is_evaluation   (rsp_is_evaluation),
      .rsp_all_satisfied   (rsp_all_satisfied),
      .rsp_satisfied_count (rsp_satisfied_count),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   task automatic report_mismatch(string msg);
      if (errors < MaxPrinted) begin
         $display("%0t ns  mismatch: %s", $time, msg);
      end
      errors++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic bit literal_true(logic signed [LitW-1:0] lit,
                                       logic [AssignW-1:0] a);
      int v;
      v = lit;
      if (v < 0) v = -v;
      // zero and variables past the last one never hold
      if (v == 0 || v > NumVars) return 1'b0;
      return (lit < 0) ? !a[v-1] : a[v-1];
   endfunction

   function automatic answer_type evaluate_formula(logic [AssignW-1:0] a);
      answer_type ans;
      int         n;
      int         c;
      int         len;
      bit         holds;
      bit         stop;
      ans.is_eval = 1'b1;
      ans.all_sat = 1'b1;
      ans.count   = '0;
      n = (cfg_clause_count > MaxClauses) ? MaxClauses : int'(cfg_clause_count);
      c = 0;
      stop = 1'b0;
      while (c < n && !stop) begin
         len = int'(len_tab[c]);
         if (len > MaxLiterals) len = MaxLiterals;
         holds = 1'b0;
         for (int s = 0; s < len; s++) begin
            if (literal_true(lit_tab[c][s], a)) holds = 1'b1;
         end
         if (holds) begin
            ans.count++;
         end else begin
            ans.all_sat = 1'b0;
            if (cfg_early_stop) stop = 1'b1;
         end
         c++;
      end
      return ans;
   endfunction

   // apply one accepted request and queue the answer it must give
   task automatic apply_request(clause_req_type r);
      answer_type ans;
      ans = '{1'b0, 1'b0, '0};
      case (r.action)
         ACT_STORE: begin
            lit_tab[r.clause][r.slot] = r.literal;
         end
         ACT_LENGTH: begin
            len_tab[r.clause] = r.length;
         end
         ACT_EVAL: begin
            ans = evaluate_formula(r.assignment);
            n_evals++;
            if (ans.all_sat) n_full++;
            else if (cfg_early_stop) n_cut++;
         end
         default: begin
         end
      endcase
      pending_answers.push_back(ans);
      n_requests++;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_request(on_port);
         end
         if (!start || !busy) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               on_port = pending_requests.pop_front();
               start             <= 1'b1;
               req_action        <= on_port.action;
               req_clause_index  <= on_port.clause;
               req_slot_index    <= on_port.slot;
               req_literal       <= on_port.literal;
               req_clause_length <= on_port.length;
               req_assignment    <= on_port.assignment;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("response with none outstanding, count %0d",
                                      rsp_satisfied_count));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_is_evaluation !== want.is_eval)
               report_mismatch($sformatf("is_evaluation %b, expected %b",
                                         rsp_is_evaluation, want.is_eval));
            if (rsp_all_satisfied !== want.all_sat)
               report_mismatch($sformatf("all_satisfied %b, expected %b",
                                         rsp_all_satisfied, want.all_sat));
            if (rsp_satisfied_count !== want.count)
               report_mismatch($sformatf("satisfied_count %0d, expected %0d",
                                         rsp_satisfied_count, want.count));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic clause_req_type blank_request(logic [ActionW-1:0] action);
      clause_req_type r;
      // unused fields carry random content too
      r.action     = action;
      r.clause     = RowW'($urandom);
      r.slot       = SlotW'($urandom);
      r.literal    = LitW'($urandom);
      r.length     = LenW'($urandom);
      r.assignment = {$urandom, $urandom};
      return r;
   endfunction

   function automatic void queue_request(clause_req_type r);
      pending_requests.push_back(r);
      if (r.action == ACT_STORE) begin
         lit_known[r.clause][r.slot] = 1'b1;
         plan_lit[r.clause][r.slot]  = r.literal;
      end else if (r.action == ACT_LENGTH) begin
         len_known[r.clause] = 1'b1;
         plan_len[r.clause]  = r.length;
      end
      if (r.action != ACT_UNUSED) queued_items++;
   endfunction

   function automatic void queue_store(int c, int s, int lit);
      clause_req_type r;
      r = blank_request(ACT_STORE);
      r.clause  = RowW'(c);
      r.slot    = SlotW'(s);
      r.literal = LitW'(lit);
      queue_request(r);
   endfunction

   function automatic void queue_length(int c, int len);
      clause_req_type r;
      r = blank_request(ACT_LENGTH);
      r.clause = RowW'(c);
      r.length = LenW'(len);
      queue_request(r);
   endfunction

   function automatic void queue_eval(logic [AssignW-1:0] a);
      clause_req_type r;
      r = blank_request(ACT_EVAL);
      r.assignment = a;
      queue_request(r);
   endfunction

   function automatic int pick_literal();
      int r;
      int v;
      r = int'($urandom_range(99));
      if (r < 8) return 0;
      if (r < 16) return int'($urandom_range(NumVars + 1, 127));
      if (r < 24) begin
         v = int'($urandom_range(NumVars + 1, 128));
         return -v;
      end
      v = int'($urandom_range(1, NumVars));
      return ($urandom_range(1) == 1) ? -v : v;
   endfunction

   // mostly short clauses, now and then a length past the slot count
   function automatic int pick_length();
      int r;
      r = int'($urandom_range(99));
      if (r < 10) return 0;
      if (r < 55) return 1;
      if (r < 72) return 2;
      if (r < 84) return 3;
      if (r < 93) return 4;
      return int'($urandom_range(MaxLiterals + 1, 7));
   endfunction

   function automatic bit clause_ready(int c);
      int len;
      if (!len_known[c]) return 1'b0;
      len = (plan_len[c] > MaxLiterals) ? MaxLiterals : int'(plan_len[c]);
      for (int s = 0; s < len; s++) begin
         if (!lit_known[c][s]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // length and literals of one clause, in either order
   function automatic void define_clause(int c);
      int len;
      int used;
      bit len_first;
      len = pick_length();
      used = (len > MaxLiterals) ? MaxLiterals : len;
      len_first = ($urandom_range(1) == 1);
      if (len_first) queue_length(c, len);
      for (int s = 0; s < used; s++) queue_store(c, s, pick_literal());
      if (!len_first) queue_length(c, len);
   endfunction

   // one positive literal in range, so an all-ones assignment satisfies the clause
   function automatic void define_short_clause(int c);
      queue_store(c, 0, int'($urandom_range(1, NumVars)));
      queue_length(c, 1);
   endfunction

   // whole table rewritten cheaply with single-literal clauses
   function automatic void fill_table();
      for (int c = 0; c < MaxClauses; c++) define_short_clause(c);
   endfunction

   function automatic int clauses_in_use();
      return (plan_count > MaxClauses) ? MaxClauses : plan_count;
   endfunction

   // evaluations only ever read clauses whose length and literals were written
   function automatic void make_ready();
      for (int c = 0; c < clauses_in_use(); c++) begin
         if (!clause_ready(c)) define_clause(c);
      end
   endfunction

   // random, extreme, or built to satisfy one chosen literal of each clause
   function automatic logic [AssignW-1:0] pick_assignment();
      logic [AssignW-1:0]     a;
      logic signed [LitW-1:0] lit;
      int                     r;
      int                     len;
      int                     v;
      a = {$urandom, $urandom};
      r = int'($urandom_range(99));
      if (r < 10) begin
         a = '0;
      end else if (r < 20) begin
         a = '1;
      end else if (r < 65) begin
         for (int c = 0; c < clauses_in_use(); c++) begin
            len = (plan_len[c] > MaxLiterals) ? MaxLiterals : int'(plan_len[c]);
            if (len > 0) begin
               lit = plan_lit[c][$urandom_range(len - 1)];
               v = lit;
               if (v < 0) v = -v;
               if (v >= 1 && v <= NumVars) a[v-1] = (lit > 0);
            end
         end
      end
      return a;
   endfunction

   task automatic wait_drained();
      int stalled;
      stalled = 0;
      @(negedge clock);
      while (pending_requests.size() != 0 || start
             || (pending_answers.size() != 0 && stalled < AnswerWait)) begin
         if (pending_requests.size() == 0 && !start) stalled++;
         @(negedge clock);
      end
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CLAUSE_COUNT) cfg_clause_count = data;
      else cfg_early_stop = data[0];
   endtask

   // new register setting once the block is idle
   task automatic configure(int count, bit early, int idle_pct);
      logic [CsrDataW-1:0] stop_word;
      wait_drained();
      sender_idle_pct = idle_pct;
      stop_word = CsrDataW'($urandom_range((1 << CsrDataW) - 1));
      stop_word[0] = early;
      write_csr(CSR_CLAUSE_COUNT, CsrDataW'(count));
      write_csr(CSR_EARLY_STOP, stop_word);
      plan_count = count;
      n_settings++;
      @(negedge clock);
   endtask

   task automatic run_random(int items);
      int goal;
      int r;
      int c;
      int n;
      make_ready();
      goal = queued_items + items;
      n = clauses_in_use();
      while (queued_items < goal) begin
         r = int'($urandom_range(99));
         c = (n > 0) ? int'($urandom_range(n - 1)) : int'($urandom_range(MaxClauses - 1));
         if (r < 15) begin
            define_clause(c);
         end else if (r < 38) begin
            queue_store(c, int'($urandom_range(MaxLiterals - 1)), pick_literal());
         end else if (r < 70) begin
            make_ready();
            queue_eval(pick_assignment());
         end else if (r < 80) begin
            // anywhere in the table, mostly outside the clauses in use
            c = int'($urandom_range(MaxClauses - 1));
            if ($urandom_range(1)) queue_store(c, int'($urandom_range(MaxLiterals - 1)),
                                               pick_literal());
            else queue_length(c, pick_length());
         end else if (r < 88) begin
            queue_request(blank_request(ACT_UNUSED));
         end else begin
            // broken sequence: length grows before its literals are stored
            queue_length(c, int'($urandom_range(2, 7)));
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty formula after reset holds vacuously; unused action answers zeros
      queue_eval({$urandom, $urandom});
      queue_request(blank_request(ACT_UNUSED));

      // three clauses: in range, out of range and zero literals, clamped and empty lengths
      configure(3, 1'b0, 31);
      queue_store(0, 0, 1);
      queue_store(0, 1, -64);
      queue_store(0, 2, 0);
      queue_store(0, 3, 65);
      queue_length(0, 4);
      queue_store(1, 0, -128);
      queue_store(1, 1, 127);
      queue_store(1, 2, -65);
      queue_store(1, 3, 64);
      queue_length(1, 7);
      queue_length(2, 0);
      queue_eval('0);
      queue_eval('1);
      queue_request(blank_request(ACT_UNUSED));

      // early stop: all satisfied, stop at the second clause, stop at the first
      configure(2, 1'b1, 31);
      queue_eval('1);
      queue_eval('0);
      queue_eval(64'h8000_0000_0000_0000);

      configure(8, 1'b0, 31);
      run_random(15);

      // full table: every clause holds, then the scan stops at the first one
      configure(MaxClauses, 1'b1, 31);
      fill_table();
      queue_eval('1);
      queue_eval('0);
      run_random(10);
      configure(1, 1'b0, 31);
      run_random(10);

      // clause count past the table size counts as the full table; then a partial and an empty formula
      configure((1 << CsrDataW) - 1, 1'b0, 69);
      run_random(10);
      configure(37, 1'b1, 69);
      run_random(10);
      configure(0, 1'b1, 69);
      run_random(10);

      configure(MaxClauses + 1, 1'b1, 0);
      run_random(10);
      configure(100, 1'b0, 0);
      run_random(10);
      configure(MaxClauses, 1'b0, 0);
      run_random(10);

      wait_drained();
      repeat (SettleCycles) @(negedge clock);
      if (pending_answers.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", pending_answers.size()));
      end

      $display("covered %0d requests and %0d evaluations over %0d register settings",
               n_requests, n_evals, n_settings);
      $display("%0d evaluations fully satisfied, %0d cut short by early stop",
               n_full, n_cut);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TimeoutNs);
      $display("Test completed with failures");
      $finish;
   end

endmodule
